@@ rtl/gclv_pkg.sv @@
`default_nettype none

package gclv_pkg;

   // Parse position within the current line.
   typedef enum logic [1:0] {
      PH_LEAD = 2'd0,
      PH_CODE = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BLANK   = 2'd0,
      KIND_VALID   = 2'd1,
      KIND_INVALID = 2'd2,
      KIND_IGNORED = 2'd3
   } line_kind_type;

   typedef enum logic [3:0] {
      ERR_NONE      = 4'd0,
      ERR_NO_LETTER = 4'd1,
      ERR_NO_CODE   = 4'd2,
      ERR_BAD_G     = 4'd3,
      ERR_BAD_M     = 4'd4,
      ERR_G01_AXIS  = 4'd5,
      ERR_G92_AXIS  = 4'd6,
      ERR_TWO_POINT = 4'd7,
      ERR_MINUS     = 4'd8,
      ERR_FORMAT    = 4'd9,
      ERR_NO_VALUE  = 4'd10
   } err_code_type;

   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
   localparam logic [7:0] CHAR_UP_G  = 8'h47;
   localparam logic [7:0] CHAR_LO_G  = 8'h67;
   localparam logic [7:0] CHAR_UP_M  = 8'h4D;
   localparam logic [7:0] CHAR_LO_M  = 8'h6D;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;
   localparam logic [7:0] CHAR_UP_Y  = 8'h59;
   localparam logic [7:0] CHAR_LO_X  = 8'h78;
   localparam logic [7:0] CHAR_LO_Y  = 8'h79;

   localparam logic [9:0] CODE_MAX = 10'd1023;

   // Everything the block remembers about the line in progress.
   typedef struct packed {
      phase_type    phase;
      logic [7:0]   first_letter;
      logic [9:0]   code_value;
      logic         code_digit_seen;
      err_code_type early_error;
      logic         axis_seen;
      logic         in_comment;
      logic         vf_scan;
      logic         vf_point;
      logic         vf_digit;
      logic         vf_nonempty;
      logic [7:0]   pending_letter;
      logic         pending_blank;
      err_code_type param_error;
      logic [7:0]   param_error_letter;
   } line_state_type;

   typedef struct packed {
      logic step;
      logic clear;
   } scan_ctl_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= CHAR_UP_A && c <= CHAR_UP_Z) || (c >= CHAR_LO_A && c <= CHAR_LO_Z);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic is_gm(input logic [7:0] c);
      return c == CHAR_UP_G || c == CHAR_LO_G || c == CHAR_UP_M || c == CHAR_LO_M;
   endfunction

endpackage

`default_nettype wire

@@ rtl/gclv_scan.sv @@
`default_nettype none

module gclv_scan
   import gclv_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire scan_ctl_type   ctl,
   input  wire logic [7:0]     char_byte,
   output line_state_type      state
);

   line_state_type state_ff;
   line_state_type state_in;

   // Parameter and value checking for one character of the line body.
   function automatic line_state_type body_char(input line_state_type s,
                                                input logic [7:0] ch);
      line_state_type r;
      logic           take_letter;
      logic           valchar;
      r           = s;
      take_letter = 1'b0;
      valchar     = is_digit(ch) || ch == CHAR_POINT || ch == CHAR_MINUS;
      if (s.early_error == ERR_NONE && s.param_error == ERR_NONE) begin
         if (s.vf_scan) begin
            if (!s.vf_nonempty) begin
               if (is_space(ch)) begin
                  r.pending_blank = 1'b1;
               end else if (s.pending_blank || !valchar) begin
                  r.param_error        = ERR_FORMAT;
                  r.param_error_letter = s.pending_letter;
               end else begin
                  r.vf_nonempty = 1'b1;
                  if (ch == CHAR_POINT) r.vf_point = 1'b1;
                  else if (is_digit(ch)) r.vf_digit = 1'b1;
               end
            end else if (valchar) begin
               if (ch == CHAR_POINT) begin
                  if (s.vf_point) begin
                     r.param_error        = ERR_TWO_POINT;
                     r.param_error_letter = s.pending_letter;
                  end else begin
                     r.vf_point = 1'b1;
                  end
               end else if (is_digit(ch)) begin
                  r.vf_digit = 1'b1;
               end else begin
                  r.param_error        = ERR_MINUS;
                  r.param_error_letter = s.pending_letter;
               end
            end else if (!s.vf_digit) begin
               r.param_error        = ERR_FORMAT;
               r.param_error_letter = s.pending_letter;
            end else begin
               r.vf_scan     = 1'b0;
               r.vf_point    = 1'b0;
               r.vf_digit    = 1'b0;
               r.vf_nonempty = 1'b0;
               take_letter   = 1'b1;
            end
         end else begin
            take_letter = 1'b1;
         end
         if (take_letter && is_alpha(ch) && !is_gm(ch)) begin
            r.vf_scan        = 1'b1;
            r.vf_point       = 1'b0;
            r.vf_digit       = 1'b0;
            r.vf_nonempty    = 1'b0;
            r.pending_letter = ch;
            r.pending_blank  = 1'b0;
         end
      end
      return r;
   endfunction

   always_comb begin
      logic        do_body;
      logic [13:0] code_next;
      state_in  = state_ff;
      do_body   = 1'b0;
      code_next = {4'd0, state_ff.code_value} * 14'd10 + {10'd0, char_byte[3:0]};
      if (ctl.clear) begin
         state_in = '0;
      end else if (ctl.step && !state_ff.in_comment) begin
         if (char_byte == CHAR_SEMI) begin
            state_in.in_comment = 1'b1;
         end else begin
            if (char_byte == CHAR_UP_X || char_byte == CHAR_UP_Y || char_byte == CHAR_UP_Z ||
                char_byte == CHAR_LO_X || char_byte == CHAR_LO_Y || char_byte == CHAR_LO_Z) begin
               state_in.axis_seen = 1'b1;
            end
            case (state_ff.phase)
               PH_LEAD: begin
                  if (!is_space(char_byte)) begin
                     state_in.first_letter = char_byte;
                     if (!is_alpha(char_byte)) begin
                        state_in.early_error = ERR_NO_LETTER;
                        state_in.phase       = PH_BODY;
                     end else if (is_gm(char_byte)) begin
                        state_in.phase = PH_CODE;
                     end else begin
                        state_in.phase = PH_BODY;
                        do_body        = 1'b1;
                     end
                  end
               end
               PH_CODE: begin
                  if (!state_ff.code_digit_seen) begin
                     if (is_digit(char_byte)) begin
                        state_in.code_digit_seen = 1'b1;
                        state_in.code_value      = {6'd0, char_byte[3:0]};
                     end else begin
                        state_in.early_error = ERR_NO_CODE;
                        state_in.phase       = PH_BODY;
                     end
                  end else if (is_digit(char_byte)) begin
                     // Digits after a decimal point do not add to the code number.
                     if (!state_ff.vf_point) begin
                        state_in.code_value = (code_next > {4'd0, CODE_MAX}) ?
                                              CODE_MAX : code_next[9:0];
                     end
                  end else if (char_byte == CHAR_POINT) begin
                     state_in.vf_point = 1'b1;
                  end else begin
                     state_in.vf_scan     = 1'b0;
                     state_in.vf_point    = 1'b0;
                     state_in.vf_digit    = 1'b0;
                     state_in.vf_nonempty = 1'b0;
                     state_in.phase       = PH_BODY;
                     do_body              = 1'b1;
                  end
               end
               PH_BODY: begin
                  do_body = 1'b1;
               end
               default: begin
                  do_body = 1'b1;
               end
            endcase
            if (do_body) state_in = body_char(state_in, char_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

`default_nettype wire

@@ rtl/gclv_check.sv @@
`default_nettype none

module gclv_check
   import gclv_pkg::*;
(
   input  wire line_state_type state,
   output err_code_type        error_code,
   output logic [9:0]          code_number,
   output logic [7:0]          param_letter
);

   logic is_g;
   logic is_m;
   logic g_ok;
   logic m_ok;
   logic late_param;

   assign is_g = state.first_letter == CHAR_UP_G || state.first_letter == CHAR_LO_G;
   assign is_m = state.first_letter == CHAR_UP_M || state.first_letter == CHAR_LO_M;

   always_comb begin
      case (state.code_value)
         10'd0, 10'd1, 10'd4, 10'd20, 10'd21, 10'd28, 10'd90, 10'd91, 10'd92: g_ok = 1'b1;
         default: g_ok = 1'b0;
      endcase
      case (state.code_value)
         10'd0, 10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd30, 10'd112: m_ok = 1'b1;
         default: m_ok = 1'b0;
      endcase
   end

   // Code errors outrank axis errors, which outrank parameter errors. A value
   // left open at the line end is judged last.
   always_comb begin
      late_param = 1'b0;
      if (state.early_error != ERR_NONE) begin
         error_code = state.early_error;
      end else if ((is_g || is_m) && !state.code_digit_seen) begin
         error_code = ERR_NO_CODE;
      end else if (is_g && !g_ok) begin
         error_code = ERR_BAD_G;
      end else if (is_g && (state.code_value == 10'd0 || state.code_value == 10'd1) &&
                   !state.axis_seen) begin
         error_code = ERR_G01_AXIS;
      end else if (is_g && state.code_value == 10'd92 && !state.axis_seen) begin
         error_code = ERR_G92_AXIS;
      end else if (is_m && !m_ok) begin
         error_code = ERR_BAD_M;
      end else if (state.param_error != ERR_NONE) begin
         error_code = state.param_error;
      end else if (state.vf_scan && !state.vf_nonempty) begin
         error_code = ERR_NO_VALUE;
         late_param = 1'b1;
      end else if (state.vf_scan && !state.vf_digit) begin
         error_code = ERR_FORMAT;
         late_param = 1'b1;
      end else begin
         error_code = ERR_NONE;
      end
   end

   always_comb begin
      if (late_param) begin
         param_letter = state.pending_letter;
      end else if (error_code == ERR_FORMAT || error_code == ERR_NO_VALUE) begin
         param_letter = state.param_error_letter;
      end else begin
         param_letter = 8'd0;
      end
   end

   assign code_number = (is_g || is_m) ? state.code_value : 10'd0;

endmodule

`default_nettype wire

@@ rtl/gcode_line_validator.sv @@
`default_nettype none

// Channel | Direction | Ports                                  | Item
// --------+-----------+----------------------------------------+------------------------------
// req     | in        | req_valid/ready, char_byte, line_end,  | one character or a line mark
//         |           | new_file                               |
// rsp     | out       | rsp_valid/ready, line_kind ... halted  | one line verdict per line end
// csr     | in        | csr_valid/ready, csr_max_errors        | error limit write
//
// An item is held in an input register; when it moves on, the line state is updated from it
// in one pass and a line end loads the result register. One item per cycle is sustained
// while the input register does not stall. It only stalls when a line end without a
// new-file mark meets a full, unread result register. Reset is synchronous and clears
// the line state, the counters, the halt flag and the error limit; the csr channel is
// always ready.

module gcode_line_validator
   import gclv_pkg::*;
#(
   parameter int COUNTER_WIDTH = 24
) (
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [7:0]               req_char_byte,
   input  wire logic                     req_line_end,
   input  wire logic                     req_new_file,

   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [1:0]                    rsp_line_kind,
   output logic [3:0]                    rsp_error_code,
   output logic [7:0]                    rsp_code_letter,
   output logic [9:0]                    rsp_code_number,
   output logic [7:0]                    rsp_param_letter,
   output logic [COUNTER_WIDTH-1:0]      rsp_line_number,
   output logic [COUNTER_WIDTH-1:0]      rsp_valid_total,
   output logic [COUNTER_WIDTH-1:0]      rsp_error_total,
   output logic                          rsp_halted_flag,

   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [15:0]              csr_max_errors
);

   // Width at which the error count is compared with the 16-bit limit.
   localparam int CMP_WIDTH = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;
   localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

   function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   // Error limit register.
   logic [15:0] max_errors_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_errors_ff <= 16'd0;
      end else if (csr_valid && csr_ready) begin
         max_errors_ff <= csr_max_errors;
      end
   end

   assign csr_ready = 1'b1;

   // Input register.
   logic       in_vld_ff;
   logic [7:0] in_char_ff;
   logic       in_le_ff;
   logic       in_nf_ff;
   logic       out_free;
   logic       makes_result;
   logic       fire;

   assign out_free     = !rsp_valid || rsp_ready;
   assign makes_result = in_le_ff && !in_nf_ff;
   assign fire         = in_vld_ff && (!makes_result || out_free);
   assign req_ready    = !in_vld_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_byte;
         in_le_ff   <= req_line_end;
         in_nf_ff   <= req_new_file;
      end
   end

   // Counters and halt flag.
   logic [COUNTER_WIDTH-1:0] line_cnt_ff, line_cnt_in;
   logic [COUNTER_WIDTH-1:0] valid_cnt_ff, valid_cnt_in;
   logic [COUNTER_WIDTH-1:0] err_cnt_ff, err_cnt_in;
   logic                     halt_ff, halt_in;

   // Line state and the verdict on it.
   scan_ctl_type   scan_ctl;
   line_state_type line_state;
   err_code_type   chk_error;
   logic [9:0]     chk_code_number;
   logic [7:0]     chk_param_letter;

   // A new-file item clears the line; so does a line end that is checked.
   assign scan_ctl.step  = fire && !in_nf_ff && !in_le_ff && !halt_ff;
   assign scan_ctl.clear = fire && (in_nf_ff || (in_le_ff && !halt_ff));

   gclv_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .char_byte (in_char_ff),
      .state     (line_state)
   );

   gclv_check u_check (
      .state        (line_state),
      .error_code   (chk_error),
      .code_number  (chk_code_number),
      .param_letter (chk_param_letter)
   );

   // Result fields for the line that closes in this cycle.
   line_kind_type res_kind;
   err_code_type  res_error;
   logic [7:0]    res_letter;
   logic [9:0]    res_number;
   logic [7:0]    res_param;

   always_comb begin
      line_cnt_in  = line_cnt_ff;
      valid_cnt_in = valid_cnt_ff;
      err_cnt_in   = err_cnt_ff;
      halt_in      = halt_ff;
      res_kind     = KIND_IGNORED;
      res_error    = ERR_NONE;
      res_letter   = 8'd0;
      res_number   = 10'd0;
      res_param    = 8'd0;
      if (fire && in_nf_ff) begin
         line_cnt_in  = '0;
         valid_cnt_in = '0;
         err_cnt_in   = '0;
         halt_in      = 1'b0;
      end else if (fire && in_le_ff && !halt_ff) begin
         line_cnt_in = sat_inc(line_cnt_ff);
         if (line_state.phase == PH_LEAD) begin
            res_kind = KIND_BLANK;
         end else begin
            res_error  = chk_error;
            res_letter = line_state.first_letter;
            res_number = chk_code_number;
            res_param  = chk_param_letter;
            if (chk_error == ERR_NONE) begin
               res_kind     = KIND_VALID;
               valid_cnt_in = sat_inc(valid_cnt_ff);
            end else begin
               res_kind   = KIND_INVALID;
               err_cnt_in = sat_inc(err_cnt_ff);
               // The limit is only looked at when an invalid line is counted.
               if (max_errors_ff != 16'd0 &&
                   CMP_WIDTH'(err_cnt_in) >= CMP_WIDTH'(max_errors_ff)) begin
                  halt_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_cnt_ff  <= '0;
         valid_cnt_ff <= '0;
         err_cnt_ff   <= '0;
         halt_ff      <= 1'b0;
      end else begin
         line_cnt_ff  <= line_cnt_in;
         valid_cnt_ff <= valid_cnt_in;
         err_cnt_ff   <= err_cnt_in;
         halt_ff      <= halt_in;
      end
   end

   // Result register.
   logic                     rsp_valid_ff;
   logic [1:0]               rsp_kind_ff;
   logic [3:0]               rsp_error_ff;
   logic [7:0]               rsp_letter_ff;
   logic [9:0]               rsp_number_ff;
   logic [7:0]               rsp_param_ff;
   logic [COUNTER_WIDTH-1:0] rsp_line_ff;
   logic [COUNTER_WIDTH-1:0] rsp_vtot_ff;
   logic [COUNTER_WIDTH-1:0] rsp_etot_ff;
   logic                     rsp_halt_ff;
   logic                     load_result;

   assign load_result = fire && makes_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_result) begin
         rsp_kind_ff   <= res_kind;
         rsp_error_ff  <= res_error;
         rsp_letter_ff <= res_letter;
         rsp_number_ff <= res_number;
         rsp_param_ff  <= res_param;
         rsp_line_ff   <= line_cnt_in;
         rsp_vtot_ff   <= valid_cnt_in;
         rsp_etot_ff   <= err_cnt_in;
         rsp_halt_ff   <= halt_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_kind    = rsp_kind_ff;
   assign rsp_error_code   = rsp_error_ff;
   assign rsp_code_letter  = rsp_letter_ff;
   assign rsp_code_number  = rsp_number_ff;
   assign rsp_param_letter = rsp_param_ff;
   assign rsp_line_number  = rsp_line_ff;
   assign rsp_valid_total  = rsp_vtot_ff;
   assign rsp_error_total  = rsp_etot_ff;
   assign rsp_halted_flag  = rsp_halt_ff;

   // The block can only be halted after at least one invalid line.
   assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> err_cnt_ff != '0)
      else $error("halted with no invalid lines counted");

   // Valid and invalid totals never run ahead of the line count.
   assert property (@(posedge clock) disable iff (reset)
      valid_cnt_ff <= line_cnt_ff && err_cnt_ff <= line_cnt_ff)
      else $error("line totals exceed line count");

   // A new-file item clears the counters and the halt flag.
   assert property (@(posedge clock) disable iff (reset)
      fire && in_nf_ff |=> line_cnt_ff == '0 && err_cnt_ff == '0 && !halt_ff)
      else $error("new file did not clear the counters");

   // An ignored line is only reported while halted.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_IGNORED |-> rsp_halt_ff)
      else $error("ignored line reported while not halted");

endmodule

`default_nettype wire

@@ bench/gcode_line_validator_test.sv @@
`timescale 1ns / 1ps

module gcode_line_validator_test;
   import gclv_pkg::*;

   // Counter width used by both the block and the line checker below.
   localparam int CW = 24;

   // Cycles to let pass after the last expected verdict.
   // A character item produces no verdict and can still be in the two-stage pipe.
   localparam int SETTLE_CYCLES = 6;

   // Length of the receiver hold-off that is meant to back the block up.
   localparam int LONG_HOLD = 200;

   // G and M code numbers that the block accepts.
   localparam int unsigned G_LIST [9] = '{0, 1, 4, 20, 21, 28, 90, 91, 92};
   localparam int unsigned M_LIST [8] = '{0, 1, 2, 3, 4, 5, 30, 112};

   // One item on the character channel.
   typedef struct packed {
      logic [7:0] ch;
      logic       line_end;
      logic       new_file;
   } stream_item_type;

   // The verdict that one line end is expected to produce.
   typedef struct packed {
      logic [1:0]    kind;
      logic [3:0]    err;
      logic [7:0]    letter;
      logic [9:0]    number;
      logic [7:0]    param;
      logic [CW-1:0] line_no;
      logic [CW-1:0] valid_no;
      logic [CW-1:0] error_no;
      logic          halted;
   } line_verdict_type;

   // Clock and reset. Reset starts high and is released by the test sequence.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   // Block inputs start at known values.
   logic          req_valid = 1'b0;
   logic [7:0]    req_char_byte = 8'd0;
   logic          req_line_end = 1'b0;
   logic          req_new_file = 1'b0;
   logic          rsp_ready = 1'b0;
   logic          csr_valid = 1'b0;
   logic [15:0]   csr_max_errors = 16'd0;

   logic          req_ready;
   logic          rsp_valid;
   logic [1:0]    rsp_line_kind;
   logic [3:0]    rsp_error_code;
   logic [7:0]    rsp_code_letter;
   logic [9:0]    rsp_code_number;
   logic [7:0]    rsp_param_letter;
   logic [CW-1:0] rsp_line_number;
   logic [CW-1:0] rsp_valid_total;
   logic [CW-1:0] rsp_error_total;
   logic          rsp_halted_flag;
   logic          csr_ready;

   gcode_line_validator #(
      .COUNTER_WIDTH(CW)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_byte    (req_char_byte),
      .req_line_end     (req_line_end),
      .req_new_file     (req_new_file),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_kind    (rsp_line_kind),
      .rsp_error_code   (rsp_error_code),
      .rsp_code_letter  (rsp_code_letter),
      .rsp_code_number  (rsp_code_number),
      .rsp_param_letter (rsp_param_letter),
      .rsp_line_number  (rsp_line_number),
      .rsp_valid_total  (rsp_valid_total),
      .rsp_error_total  (rsp_error_total),
      .rsp_halted_flag  (rsp_halted_flag),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_max_errors   (csr_max_errors)
   );

   // ---------------------------------------------------------------------------------------
   // Line checker state. This is an independent copy of what the block must remember
   // about the line in progress, plus the counters, the halt flag and the error limit.
   // ---------------------------------------------------------------------------------------
   phase_type     scan_phase;
   logic [7:0]    lead_char;
   logic [9:0]    code_num;
   logic          code_has_digit;
   err_code_type  early_fault;
   logic          axis_hit;
   logic          comment_on;
   logic          val_scan;
   logic          val_point;
   logic          val_digit;
   logic          val_nonempty;
   logic [7:0]    param_key;
   logic          key_then_blank;
   err_code_type  param_fault;
   logic [7:0]    param_fault_key;
   logic [CW-1:0] lines_seen;
   logic [CW-1:0] valid_seen;
   logic [CW-1:0] errors_seen;
   logic          halted;
   logic [15:0]   limit_copy;

   // Testbench bookkeeping.
   stream_item_type  pending_items [$];
   line_verdict_type line_verdicts [$];
   stream_item_type  upcoming;
   stream_item_type  taken;
   line_verdict_type verdict;
   int unsigned   items_queued = 0;
   int unsigned   items_accepted = 0;
   int unsigned   send_pause = 0;
   int unsigned   hold_left = 0;
   logic          send_idle_on = 1'b1;
   logic          recv_idle_on = 1'b1;
   logic          long_hold_request = 1'b0;
   int unsigned   failures = 0;
   int unsigned   kind_tally [4] = '{0, 0, 0, 0};
   logic [15:0]   codes_seen = 16'd0;

   // Character classes as the checker sees them. Bytes above 127 fall in none of them.
   function automatic logic is_blank_char(input logic [7:0] c);
      return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic logic is_digit_char(input logic [7:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   function automatic logic is_letter_char(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_gm_letter(input logic [7:0] c);
      return c == "G" || c == "g" || c == "M" || c == "m";
   endfunction

   function automatic logic is_value_char(input logic [7:0] c);
      return is_digit_char(c) || c == CHAR_POINT || c == CHAR_MINUS;
   endfunction

   function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic logic g_code_known(input logic [9:0] n);
      foreach (G_LIST[k]) if (G_LIST[k] == n) return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic m_code_known(input logic [9:0] n);
      foreach (M_LIST[k]) if (M_LIST[k] == n) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void forget_line();
      scan_phase = PH_LEAD;
      lead_char = 8'd0;
      code_num = 10'd0;
      code_has_digit = 1'b0;
      early_fault = ERR_NONE;
      axis_hit = 1'b0;
      comment_on = 1'b0;
      val_scan = 1'b0;
      val_point = 1'b0;
      val_digit = 1'b0;
      val_nonempty = 1'b0;
      param_key = 8'd0;
      key_then_blank = 1'b0;
      param_fault = ERR_NONE;
      param_fault_key = 8'd0;
   endfunction

   function automatic void forget_file();
      forget_line();
      lines_seen = '0;
      valid_seen = '0;
      errors_seen = '0;
      halted = 1'b0;
   endfunction

   function automatic void clear_value();
      val_scan = 1'b0;
      val_point = 1'b0;
      val_digit = 1'b0;
      val_nonempty = 1'b0;
   endfunction

   // Only the first parameter error of a line is kept, together with its letter.
   function automatic void note_param_fault(input err_code_type code);
      param_fault = code;
      param_fault_key = param_key;
   endfunction

   // A character after the code word: parameter letters and their values.
   function automatic void scan_param_char(input logic [7:0] ch);
      if (early_fault != ERR_NONE || param_fault != ERR_NONE) return;
      if (val_scan) begin
         if (!val_nonempty) begin
            // Whitespace between a letter and its value is only an error if text follows.
            if (is_blank_char(ch)) begin
               key_then_blank = 1'b1;
               return;
            end
            if (key_then_blank || !is_value_char(ch)) begin
               note_param_fault(ERR_FORMAT);
               return;
            end
            val_nonempty = 1'b1;
            if (ch == CHAR_POINT) val_point = 1'b1;
            else if (is_digit_char(ch)) val_digit = 1'b1;
            return;
         end
         if (is_value_char(ch)) begin
            if (ch == CHAR_POINT) begin
               if (val_point) note_param_fault(ERR_TWO_POINT);
               else val_point = 1'b1;
            end else if (is_digit_char(ch)) begin
               val_digit = 1'b1;
            end else begin
               note_param_fault(ERR_MINUS);
            end
            return;
         end
         // Any other character ends the value, which needs at least one digit.
         if (!val_digit) begin
            note_param_fault(ERR_FORMAT);
            return;
         end
         clear_value();
      end
      if (is_letter_char(ch) && !is_gm_letter(ch)) begin
         clear_value();
         val_scan = 1'b1;
         param_key = ch;
         key_then_blank = 1'b0;
      end
   endfunction

   // One character of a line, with comment stripping and the leading code word.
   function automatic void scan_line_char(input logic [7:0] ch);
      int unsigned grown;
      if (comment_on) return;
      if (ch == CHAR_SEMI) begin
         comment_on = 1'b1;
         return;
      end
      if (ch == "X" || ch == "Y" || ch == "Z" || ch == "x" || ch == "y" || ch == "z")
         axis_hit = 1'b1;
      if (scan_phase == PH_LEAD) begin
         if (is_blank_char(ch)) return;
         lead_char = ch;
         if (!is_letter_char(ch)) begin
            early_fault = ERR_NO_LETTER;
            scan_phase = PH_BODY;
         end else if (is_gm_letter(ch)) begin
            scan_phase = PH_CODE;
         end else begin
            scan_phase = PH_BODY;
            scan_param_char(ch);
         end
         return;
      end
      if (scan_phase == PH_CODE) begin
         if (!code_has_digit) begin
            if (is_digit_char(ch)) begin
               code_has_digit = 1'b1;
               code_num = 10'(ch - CHAR_ZERO);
            end else begin
               early_fault = ERR_NO_CODE;
               scan_phase = PH_BODY;
            end
            return;
         end
         // Digits after a decimal point do not change the code number.
         if (is_digit_char(ch)) begin
            if (!val_point) begin
               grown = code_num * 10 + (ch - CHAR_ZERO);
               code_num = (grown > 1023) ? CODE_MAX : grown[9:0];
            end
            return;
         end
         if (ch == CHAR_POINT) begin
            val_point = 1'b1;
            return;
         end
         clear_value();
         scan_phase = PH_BODY;
      end
      scan_param_char(ch);
   endfunction

   // Error of a finished line, in order of precedence.
   function automatic err_code_type line_fault();
      logic is_g;
      logic is_m;
      is_g = lead_char == "G" || lead_char == "g";
      is_m = lead_char == "M" || lead_char == "m";
      if (early_fault != ERR_NONE) return early_fault;
      if ((is_g || is_m) && !code_has_digit) return ERR_NO_CODE;
      if (is_g) begin
         if (!g_code_known(code_num)) return ERR_BAD_G;
         if ((code_num == 10'd0 || code_num == 10'd1) && !axis_hit) return ERR_G01_AXIS;
         if (code_num == 10'd92 && !axis_hit) return ERR_G92_AXIS;
      end else if (is_m) begin
         if (!m_code_known(code_num)) return ERR_BAD_M;
      end
      if (param_fault != ERR_NONE) return param_fault;
      // A value still open at the line end.
      if (val_scan) begin
         if (!val_nonempty) begin
            note_param_fault(ERR_NO_VALUE);
            return ERR_NO_VALUE;
         end
         if (!val_digit) begin
            note_param_fault(ERR_FORMAT);
            return ERR_FORMAT;
         end
      end
      return ERR_NONE;
   endfunction

   // Applies one accepted item and returns 1 when it produces a line verdict.
   function automatic logic classify_item(input stream_item_type item,
                                          output line_verdict_type v);
      err_code_type fault;
      v = '0;
      v.kind = KIND_IGNORED;
      // A new-file mark wins over a line end in the same item.
      if (item.new_file) begin
         forget_file();
         return 1'b0;
      end
      if (!item.line_end) begin
         if (!halted) scan_line_char(item.ch);
         return 1'b0;
      end
      if (!halted) begin
         lines_seen = bump(lines_seen);
         if (scan_phase == PH_LEAD) begin
            v.kind = KIND_BLANK;
         end else begin
            fault = line_fault();
            v.err = fault;
            v.letter = lead_char;
            if (is_gm_letter(lead_char)) v.number = code_num;
            if (fault == ERR_FORMAT || fault == ERR_NO_VALUE) v.param = param_fault_key;
            if (fault == ERR_NONE) begin
               v.kind = KIND_VALID;
               valid_seen = bump(valid_seen);
            end else begin
               v.kind = KIND_INVALID;
               errors_seen = bump(errors_seen);
               // The limit is only looked at when an invalid line is counted.
               if (limit_copy != 16'd0 && errors_seen >= limit_copy) halted = 1'b1;
            end
         end
         forget_line();
      end
      v.line_no = lines_seen;
      v.valid_no = valid_seen;
      v.error_no = errors_seen;
      v.halted = halted;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers. They only fill the queue of pending items; the driver paces them.
   // ---------------------------------------------------------------------------------------
   function automatic void push_item(input logic [7:0] ch, input logic le, input logic nf);
      stream_item_type item;
      item.ch = ch;
      item.line_end = le;
      item.new_file = nf;
      pending_items.insert(pending_items.size(), item);
      items_queued++;
   endfunction

   function automatic void push_char(input logic [7:0] ch);
      push_item(ch, 1'b0, 1'b0);
   endfunction

   // A line end carries a random byte, which the block must ignore.
   function automatic void end_line();
      push_item(8'($urandom_range(255)), 1'b1, 1'b0);
   endfunction

   function automatic void push_new_file();
      push_item(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
   endfunction

   function automatic void push_text(input string s);
      foreach (s[k]) push_char(s[k]);
   endfunction

   function automatic void push_blanks(input int unsigned n);
      repeat (n) push_char(($urandom_range(3) == 0) ? 8'($urandom_range(13, 9)) : CHAR_SPACE);
   endfunction

   function automatic void push_digits(input int unsigned n);
      repeat (n) push_char(8'(CHAR_ZERO + $urandom_range(9)));
   endfunction

   function automatic void push_comment();
      push_char(CHAR_SEMI);
      repeat ($urandom_range(6)) push_char(8'($urandom_range(255)));
   endfunction

   // A parameter letter other than G or M, biased toward the axes.
   function automatic logic [7:0] param_key_char();
      logic [7:0] c;
      case ($urandom_range(4))
         0: c = "X";
         1: c = "Y";
         2: c = "Z";
         default: begin
            c = 8'($urandom_range(8'h5A, 8'h41));
            while (c == "G" || c == "M") c = 8'($urandom_range(8'h5A, 8'h41));
         end
      endcase
      if ($urandom_range(3) == 0) c = c | 8'h20;
      return c;
   endfunction

   // A well-formed number: optional sign, and at least one digit around an optional point.
   function automatic void push_good_value();
      int unsigned whole;
      if ($urandom_range(3) == 0) push_char(CHAR_MINUS);
      whole = $urandom_range(4);
      push_digits(whole);
      if (whole == 0 || $urandom_range(2) == 0) begin
         push_char(CHAR_POINT);
         push_digits((whole == 0) ? $urandom_range(3, 1) : $urandom_range(3));
      end
   endfunction

   // A G or M code number; mostly supported ones, sometimes large enough to saturate.
   function automatic void push_code(input logic is_g);
      int unsigned roll;
      int unsigned pick;
      roll = $urandom_range(9);
      if (roll < 7) pick = is_g ? G_LIST[$urandom_range(8)] : M_LIST[$urandom_range(7)];
      else if (roll < 9) pick = $urandom_range(130);
      else pick = $urandom_range(99999, 1000);
      if ($urandom_range(5) == 0) push_char(CHAR_ZERO);
      push_text($sformatf("%0d", pick));
      if ($urandom_range(7) == 0) begin
         push_char(CHAR_POINT);
         push_digits($urandom_range(2));
      end
   endfunction

   // A parameter broken in one of the ways the checker must catch.
   function automatic void push_bad_param();
      push_char(param_key_char());
      case ($urandom_range(6))
         0: begin
            push_digits($urandom_range(2, 1));
            push_char(CHAR_POINT);
            push_digits($urandom_range(1));
            push_char(CHAR_POINT);
         end
         1: begin
            push_digits($urandom_range(2, 1));
            push_char(CHAR_MINUS);
         end
         2: begin
            push_blanks($urandom_range(2, 1));
            push_good_value();
         end
         3: push_blanks($urandom_range(2));
         4: begin
            push_char(CHAR_POINT);
            push_blanks(1);
         end
         5: push_char(8'($urandom_range(8'hFF, 8'h80)));
         default: push_char(8'($urandom_range(8'h2F, 8'h21)));
      endcase
   endfunction

   // One random line followed by its line end. Most lines are well formed, some carry
   // one defect, and a few are pure noise.
   function automatic void push_random_line();
      int unsigned roll;
      int unsigned head;
      int unsigned spoil;
      int unsigned params;
      int unsigned bad_at;
      int unsigned i;
      logic        broken;
      logic        gm;
      logic [7:0]  lead;
      roll = $urandom_range(99);
      push_blanks(($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0);
      if (roll < 8) begin
         push_blanks($urandom_range(2));
         if ($urandom_range(1)) push_comment();
      end else if (roll < 90) begin
         broken = (roll >= 72);
         head = $urandom_range(99);
         if (head < 50) lead = $urandom_range(1) ? CHAR_UP_G : CHAR_LO_G;
         else if (head < 70) lead = $urandom_range(1) ? CHAR_UP_M : CHAR_LO_M;
         else lead = param_key_char();
         gm = (head < 70);
         // Defects in the head: a digit or a high byte up front, or a missing code number.
         spoil = broken ? $urandom_range(5) : 5;
         if (spoil == 0) push_char(8'($urandom_range(8'h39, 8'h30)));
         else if (spoil == 1) push_char(8'($urandom_range(8'hFF, 8'h80)));
         push_char(lead);
         if (gm && spoil != 2) push_code(head < 50);
         else if (!gm) push_good_value();
         params = $urandom_range(4);
         if (broken && spoil > 2 && params == 0) params = 1;
         bad_at = (broken && spoil > 2) ? $urandom_range(params - 1) : params;
         for (i = 0; i < params; i++) begin
            push_blanks(($urandom_range(2) == 0) ? $urandom_range(2, 1) : 0);
            if (i == bad_at) begin
               push_bad_param();
            end else begin
               push_char(param_key_char());
               push_good_value();
            end
         end
         if ($urandom_range(4) == 0) push_comment();
         push_blanks($urandom_range(1));
      end else begin
         repeat ($urandom_range(12, 1)) push_char(8'($urandom_range(255)));
      end
      end_line();
   endfunction

   // Random lines worth about n items. Some lines are preceded by a partial line cut off
   // by a new-file mark.
   function automatic void push_random_lines(input int unsigned n, input int unsigned nf_pct);
      int unsigned stop;
      stop = items_queued + n;
      while (items_queued < stop) begin
         if ($urandom_range(99) < nf_pct) begin
            repeat ($urandom_range(3)) push_char(8'($urandom_range(8'h7E, 8'h20)));
            push_new_file();
         end
         push_random_line();
      end
   endfunction

   // Mostly no pause, sometimes a short one, rarely a long one.
   function automatic int unsigned pick_pause();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endtask

   task automatic compare_verdict(input line_verdict_type want);
      check_field("line_kind", want.kind, rsp_line_kind);
      check_field("error_code", want.err, rsp_error_code);
      check_field("code_letter", want.letter, rsp_code_letter);
      check_field("code_number", want.number, rsp_code_number);
      check_field("param_letter", want.param, rsp_param_letter);
      check_field("line_number", want.line_no, rsp_line_number);
      check_field("valid_total", want.valid_no, rsp_valid_total);
      check_field("error_total", want.error_no, rsp_error_total);
      check_field("halted_flag", want.halted, rsp_halted_flag);
      kind_tally[want.kind]++;
      codes_seen[want.err] = 1'b1;
   endtask

   // Waits until every queued item has been taken and every verdict has come back, then
   // lets the pipe settle so that a trailing character item is fully absorbed.
   task automatic wait_idle();
      while (items_accepted != items_queued || line_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the error limit. Only called while the block has nothing in flight.
   task automatic write_limit(input logic [15:0] value);
      @(posedge clock);
      csr_max_errors <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------------
   // Driver: offers pending items one at a time. Once valid is up, the payload holds
   // until the item is taken. Random pauses go between items when idling is enabled.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready) begin
            if (send_pause > 0) begin
               send_pause--;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               upcoming = pending_items.pop_front();
               req_char_byte <= upcoming.ch;
               req_line_end <= upcoming.line_end;
               req_new_file <= upcoming.new_file;
               req_valid <= 1'b1;
               if (send_idle_on) send_pause = pick_pause();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: tracks the limit register, runs the line checker on every accepted item,
   // compares each accepted verdict with the oldest expected one, and throttles the
   // result channel. The order inside one edge is fixed: register, item, verdict.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) limit_copy = csr_max_errors;
         if (req_valid && req_ready) begin
            items_accepted++;
            taken.ch = req_char_byte;
            taken.line_end = req_line_end;
            taken.new_file = req_new_file;
            if (classify_item(taken, verdict))
               line_verdicts.insert(line_verdicts.size(), verdict);
         end
         if (rsp_valid && rsp_ready) begin
            if (line_verdicts.size() == 0) begin
               $error("line verdict arrived with none expected");
               failures++;
            end else begin
               compare_verdict(line_verdicts.pop_front());
            end
         end
         // A requested long hold-off replaces whatever short stall is running.
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (recv_idle_on) hold_left = pick_pause();
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------------------------
   initial begin
      forget_file();
      limit_copy = 16'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // No limit: directed lines first, then a random mix with both sides idling.
      write_limit(16'd0);
      push_text("\t;");      // whitespace and a comment only: blank line
      end_line();
      push_text("g0");       // G0 without an axis
      end_line();
      push_text("M1024");    // code number saturates and is not a known M code
      end_line();
      push_text("Z 1");      // letter, whitespace, then a value
      end_line();
      push_char(8'hFF);      // a byte above 127 where the code letter should be
      end_line();
      push_item(8'hFF, 1'b1, 1'b1);   // both marks at once: only the new file counts
      push_text("G92Y");     // axis present, but the last letter has no value
      end_line();
      push_text("M3");
      end_line();
      push_random_lines(110, 0);
      wait_idle();

      // Highest limit. The sender runs flat out while the receiver holds off for a long
      // stretch, so the result register fills and the block must stall its input.
      write_limit(16'hFFFF);
      send_idle_on = 1'b0;
      long_hold_request = 1'b1;
      push_random_lines(150, 5);
      wait_idle();
      send_idle_on = 1'b1;

      // Limit of one: the first invalid line halts checking, and frequent new-file
      // marks bring it back.
      write_limit(16'd1);
      push_random_lines(70, 20);
      wait_idle();

      // A limit that is not reached, with no idling on either side.
      write_limit(16'd40);
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      push_random_lines(130, 0);
      wait_idle();
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;

      // The limit drops below the error count already reached; the halt comes with the
      // next invalid line.
      write_limit(16'd2);
      push_random_lines(70, 10);
      wait_idle();

      $display("Sent %0d items; checked %0d blank, %0d valid, %0d invalid, %0d halted lines.",
               items_accepted, kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3]);
      $display("Limits 0, 65535, 1, 40 and 2 were used; %0d of 11 error codes came up.",
               $countones(codes_seen));
      if (failures == 0) begin
         $display("gcode_line_validator_test OK");
      end else begin
         $display("gcode_line_validator_test NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("gcode_line_validator_test NOT OK");
      $finish;
   end

endmodule
